/* hw/rtl/plrsu_pkg.sv */
package plrsu_pkg;

  localparam int unsigned XLEN = 32;

  // Operation codes carried in tuser
  localparam logic [4:0] FUNC_EXTSB  = 5'd0;
  localparam logic [4:0] FUNC_EXTSH  = 5'd1;
  localparam logic [4:0] FUNC_CNTLZW = 5'd2;
  localparam logic [4:0] FUNC_AND    = 5'd3;
  localparam logic [4:0] FUNC_ANDC   = 5'd4;
  localparam logic [4:0] FUNC_ANDI   = 5'd5;
  localparam logic [4:0] FUNC_ANDIS  = 5'd6;
  localparam logic [4:0] FUNC_OR     = 5'd7;
  localparam logic [4:0] FUNC_ORC    = 5'd8;
  localparam logic [4:0] FUNC_ORI    = 5'd9;
  localparam logic [4:0] FUNC_ORIS   = 5'd10;
  localparam logic [4:0] FUNC_XOR    = 5'd11;
  localparam logic [4:0] FUNC_XORI   = 5'd12;
  localparam logic [4:0] FUNC_XORIS  = 5'd13;
  localparam logic [4:0] FUNC_EQV    = 5'd14;
  localparam logic [4:0] FUNC_NAND   = 5'd15;
  localparam logic [4:0] FUNC_NOR    = 5'd16;
  localparam logic [4:0] FUNC_RLWINM = 5'd17;
  localparam logic [4:0] FUNC_RLWNM  = 5'd18;
  localparam logic [4:0] FUNC_RLWIMI = 5'd19;
  localparam logic [4:0] FUNC_SLW    = 5'd20;
  localparam logic [4:0] FUNC_SRW    = 5'd21;
  localparam logic [4:0] FUNC_SRAW   = 5'd22;
  localparam logic [4:0] FUNC_SRAWI  = 5'd23;

  // CR0 field codes (LT, GT, EQ at bits 3..1)
  localparam logic [2:0] CR_LT = 3'b100;
  localparam logic [2:0] CR_GT = 3'b010;
  localparam logic [2:0] CR_EQ = 3'b001;

  localparam int unsigned S_TDATA_W = 136;
  localparam int unsigned M_TDATA_W = 40;

  typedef struct packed {
    logic [4:0]      func;
    logic [XLEN-1:0] source_value;
    logic [XLEN-1:0] second_value;
    logic [XLEN-1:0] dest_old_value;
    logic [15:0]     immediate;
    logic [4:0]      shift_amount;
    logic [4:0]      mask_begin;
    logic [4:0]      mask_end;
    logic            record;
    logic            summary_overflow;
  } plrsu_op_t;

  typedef struct packed {
    logic [XLEN-1:0] result;
    logic            carry;
    logic            carry_written;
    logic            cr0_written;
    logic [3:0]      cr0;
  } plrsu_res_t;

endpackage

/* hw/rtl/plrsu_exec.sv */
module plrsu_exec (
  input  plrsu_pkg::plrsu_op_t  op,
  output plrsu_pkg::plrsu_res_t res
);
  import plrsu_pkg::*;

  logic [XLEN-1:0]   rs;
  logic [XLEN-1:0]   rb;
  logic [XLEN-1:0]   ui_lo;
  logic [XLEN-1:0]   ui_hi;
  logic [4:0]        rot_n;
  logic [2*XLEN-1:0] rot_wide;
  logic [XLEN-1:0]   rotated;
  logic [XLEN-1:0]   from_begin;
  logic [XLEN-1:0]   to_end;
  logic [XLEN-1:0]   mask;
  logic [5:0]        lz;
  logic [4:0]        sra_n;
  logic [XLEN-1:0]   sra_val;
  logic              sra_ca;
  logic              neg;
  logic [XLEN-1:0]   value;
  logic              ca;
  logic              ca_w;
  logic              rec;

  assign rs    = op.source_value;
  assign rb    = op.second_value;
  assign ui_lo = {16'd0, op.immediate};
  assign ui_hi = {op.immediate, 16'd0};
  assign neg   = rs[XLEN-1];

  // rlwnm takes its count from the register, the others from the immediate
  assign rot_n    = (op.func == FUNC_RLWNM) ? rb[4:0] : op.shift_amount;
  assign rot_wide = {rs, rs} << rot_n;
  assign rotated  = rot_wide[2*XLEN-1:XLEN];

  // Big-endian bit numbering; wrap when begin is past end
  assign from_begin = {XLEN{1'b1}} >> op.mask_begin;
  assign to_end     = {XLEN{1'b1}} << (~op.mask_end);
  assign mask       = (op.mask_begin <= op.mask_end) ? (from_begin & to_end)
                                                     : (from_begin | to_end);

  // Priority encode: highest set bit wins
  always_comb begin
    lz = 6'd32;
    for (int i = 0; i < XLEN; i++) begin
      if (rs[i]) begin
        lz = 6'(XLEN - 1 - i);
      end
    end
  end

  assign sra_n   = (op.func == FUNC_SRAW) ? rb[4:0] : op.shift_amount;
  assign sra_val = XLEN'($signed(rs) >>> sra_n);
  assign sra_ca  = neg && ((rs & ~({XLEN{1'b1}} << sra_n)) != '0);

  always_comb begin
    value = op.dest_old_value;
    ca    = 1'b0;
    ca_w  = 1'b0;
    rec   = op.record;
    unique case (op.func)
      FUNC_EXTSB:  value = {{24{rs[7]}}, rs[7:0]};
      FUNC_EXTSH:  value = {{16{rs[15]}}, rs[15:0]};
      FUNC_CNTLZW: value = {26'd0, lz};
      FUNC_AND:    value = rs & rb;
      FUNC_ANDC:   value = rs & ~rb;
      FUNC_ANDI: begin
        value = rs & ui_lo;
        rec   = 1'b1;
      end
      FUNC_ANDIS: begin
        value = rs & ui_hi;
        rec   = 1'b1;
      end
      FUNC_OR:     value = rs | rb;
      FUNC_ORC:    value = rs | ~rb;
      FUNC_ORI:    value = rs | ui_lo;
      FUNC_ORIS:   value = rs | ui_hi;
      FUNC_XOR:    value = rs ^ rb;
      FUNC_XORI:   value = rs ^ ui_lo;
      FUNC_XORIS:  value = rs ^ ui_hi;
      FUNC_EQV:    value = ~(rs ^ rb);
      FUNC_NAND:   value = ~(rs & rb);
      FUNC_NOR:    value = ~(rs | rb);
      FUNC_RLWINM: value = rotated & mask;
      FUNC_RLWNM:  value = rotated & mask;
      FUNC_RLWIMI: value = (rotated & mask) | (op.dest_old_value & ~mask);
      FUNC_SLW:    value = rb[5] ? '0 : (rs << rb[4:0]);
      FUNC_SRW:    value = rb[5] ? '0 : (rs >> rb[4:0]);
      FUNC_SRAW: begin
        ca_w = 1'b1;
        if (rb[5]) begin
          value = {XLEN{neg}};
          ca    = neg;
        end else begin
          value = sra_val;
          ca    = sra_ca;
        end
      end
      FUNC_SRAWI: begin
        ca_w  = 1'b1;
        value = sra_val;
        ca    = sra_ca;
      end
      default: begin
        // unused codes pass the old destination through
        value = op.dest_old_value;
        rec   = 1'b0;
      end
    endcase
  end

  always_comb begin
    res.result        = value;
    res.carry         = ca;
    res.carry_written = ca_w;
    res.cr0_written   = rec;
    res.cr0           = '0;
    if (rec) begin
      if (value[XLEN-1]) begin
        res.cr0 = {CR_LT, op.summary_overflow};
      end else if (value != '0) begin
        res.cr0 = {CR_GT, op.summary_overflow};
      end else begin
        res.cr0 = {CR_EQ, op.summary_overflow};
      end
    end
  end

endmodule

/* hw/rtl/ppc_logical_rotate_shift_unit.sv */
// Datapath: each accepted input word is held in the input register, then goes
// through one pass of logic into the result register, from which it is offered
// on the master side.
// Throughput: one word per cycle; the slave side stays ready while the
// result register is free or being drained in the same cycle.
// Reset: synchronous active-high rst clears both valid flags; data holds.
module ppc_logical_rotate_shift_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // source_value[31:0], second_value[63:32], dest_old_value[95:64],
  // immediate[111:96], shift_amount[116:112], mask_begin[121:117],
  // mask_end[126:122], record[127], summary_overflow[128], zero pad
  input  logic [plrsu_pkg::S_TDATA_W-1:0]   s_tdata,
  // func[4:0]
  input  logic [4:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // result[31:0], carry[32], carry_written[33], cr0_written[34],
  // cr0[38:35], zero pad
  output logic [plrsu_pkg::M_TDATA_W-1:0]   m_tdata
);
  import plrsu_pkg::*;

  plrsu_op_t  in_word;
  plrsu_op_t  op;
  logic       op_valid;
  plrsu_res_t res_next;
  plrsu_res_t res;
  logic       res_valid;
  logic       res_load;

  always_comb begin
    in_word.func             = s_tuser;
    in_word.source_value     = s_tdata[31:0];
    in_word.second_value     = s_tdata[63:32];
    in_word.dest_old_value   = s_tdata[95:64];
    in_word.immediate        = s_tdata[111:96];
    in_word.shift_amount     = s_tdata[116:112];
    in_word.mask_begin       = s_tdata[121:117];
    in_word.mask_end         = s_tdata[126:122];
    in_word.record           = s_tdata[127];
    in_word.summary_overflow = s_tdata[128];
  end

  // advance the input word when the result register can take it
  assign res_load = !res_valid || m_tready;
  assign s_tready = !op_valid || res_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (s_tready) begin
      op_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      op <= in_word;
    end
  end

  plrsu_exec u_exec (
    .op  (op),
    .res (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= op_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load && op_valid) begin
      res <= res_next;
    end
  end

  assign m_tvalid = res_valid;
  assign m_tdata  = {1'b0, res.cr0, res.cr0_written, res.carry_written, res.carry,
                     res.result};

endmodule
